### rtl/core/tem_pkg.sv
// ============================================================================
// Touch event message encoder package
// Shared types, event codes, message constants and coordinate scaling.
// ============================================================================
package tem_pkg;

  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned RAW_W   = 12;
  localparam int unsigned STAMP_W = 63;
  localparam int unsigned PIX_X_W = 10;
  localparam int unsigned PIX_Y_W = 9;

  // Event kinds
  localparam logic [FUNC_W-1:0] FN_POS_X   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POS_Y   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CONTACT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SYNC    = 3'd3;

  localparam logic [RAW_W-1:0] CONTACT_PRESSED = 12'd1;

  typedef enum logic [1:0] {
    ACT_DOWN = 2'd0,
    ACT_UP   = 2'd1,
    ACT_MOVE = 2'd2
  } action_e;

  // X: q = floor((v-100)*512/2457) via reciprocal, exact for 12-bit v
  localparam logic [RAW_W-1:0] X_OFFSET = 12'd100;
  localparam logic [21:0]      X_RECIP  = 22'd3496107;  // ceil(2^33/2457)
  localparam int unsigned      X_SHIFT  = 24;
  localparam logic [PIX_X_W-1:0] X_BORDER = 10'd25;

  // Y: floor(v*32/273) via reciprocal, exact for 12-bit v
  localparam logic [17:0]      Y_RECIP  = 18'd245821;   // ceil(2^26/273)
  localparam int unsigned      Y_SHIFT  = 21;

  // One pending message, snapshot taken at the sync event
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PIX_X_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    action_e            act;
  } msg_desc_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'h01;
      default: b = 8'h08;
    endcase
    return b;
  endfunction

  // Size bytes, patched with the summed coordinate encoding length (3..5)
  function automatic logic [7:0] size_byte(input logic [1:0] idx, input logic [2:0] len);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h1a;
      2'd1:    b = 8'h09 + {5'd0, len};
      2'd2:    b = 8'h0a;
      default: b = 8'h03 + {5'd0, len};
    endcase
    return b;
  endfunction

  function automatic logic [7:0] foot_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h10;
      2'd1:    b = 8'h00;
      default: b = 8'h18;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/tem_if.sv
// ============================================================================
// Touch event message encoder channels
// Valid/ready interfaces for the event input and the message byte output.
// ============================================================================
interface tem_in_if;
  import tem_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [RAW_W-1:0]   raw_value;
  logic [STAMP_W-1:0] stamp_ns;

  modport source (output valid, func, raw_value, stamp_ns, input ready);
  modport sink   (input valid, func, raw_value, stamp_ns, output ready);
endinterface

interface tem_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/core/tem_front.sv
// ============================================================================
// Touch event front end
// Accepts events, scales positions, tracks the action, queues sync messages.
// ============================================================================
module tem_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  tem_in_if.sink              evt_i,
  input  logic                full_i,
  output logic                push_o,
  output tem_pkg::msg_desc_t  desc_o
);
  import tem_pkg::*;

  logic [PIX_X_W-1:0] pixel_x_q, pixel_x_d;
  logic [PIX_Y_W-1:0] pixel_y_q, pixel_y_d;
  action_e            action_q, action_d;
  logic               seen_q, seen_d;

  logic               accept;
  logic [RAW_W-1:0]   x_diff;
  logic [33:0]        x_prod;
  logic [PIX_X_W-1:0] x_quot;
  logic [29:0]        y_prod;
  action_e            sync_act;

  assign evt_i.ready = !full_i;
  assign accept      = evt_i.valid && evt_i.ready;

  // X scaling; raw at or below the offset gives zero
  assign x_diff = (evt_i.raw_value > X_OFFSET) ? (evt_i.raw_value - X_OFFSET) : '0;
  assign x_prod = 34'(x_diff) * 34'(X_RECIP);
  assign x_quot = x_prod[X_SHIFT +: PIX_X_W];

  assign y_prod = 30'(evt_i.raw_value) * 30'(Y_RECIP);

  assign sync_act = seen_q ? action_q : ACT_MOVE;

  always_comb begin
    pixel_x_d = pixel_x_q;
    pixel_y_d = pixel_y_q;
    action_d  = action_q;
    seen_d    = seen_q;
    push_o    = 1'b0;
    if (accept) begin
      case (evt_i.func)
        FN_POS_X: begin
          pixel_x_d = (x_quot < X_BORDER) ? '0 : (x_quot - X_BORDER);
        end
        FN_POS_Y: begin
          pixel_y_d = y_prod[Y_SHIFT +: PIX_Y_W];
        end
        FN_CONTACT: begin
          seen_d   = 1'b1;
          action_d = (evt_i.raw_value == CONTACT_PRESSED) ? ACT_DOWN : ACT_UP;
        end
        FN_SYNC: begin
          push_o   = 1'b1;
          action_d = sync_act;
          seen_d   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign desc_o.stamp = evt_i.stamp_ns;
  assign desc_o.x     = pixel_x_q;
  assign desc_o.y     = pixel_y_q;
  assign desc_o.act   = sync_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_x_q <= '0;
      pixel_y_q <= '0;
      action_q  <= ACT_DOWN;
      seen_q    <= 1'b0;
    end else begin
      pixel_x_q <= pixel_x_d;
      pixel_y_q <= pixel_y_d;
      action_q  <= action_d;
      seen_q    <= seen_d;
    end
  end

endmodule

### rtl/core/tem_queue.sv
// ============================================================================
// Touch event message queue
// Small register FIFO of message snapshots between front and back ends.
// ============================================================================
module tem_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tem_pkg::msg_desc_t  push_data_i,
  output logic                full_o,
  input  logic                pop_i,
  output tem_pkg::msg_desc_t  pop_data_o,
  output logic                empty_o
);
  import tem_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  msg_desc_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= count_q + 1'b1;
      else if (pop_i && !push_i) count_q <= count_q - 1'b1;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");
`endif

endmodule

### rtl/core/tem_back.sv
// ============================================================================
// Touch event message serializer
// Turns a queued snapshot into message bytes, one per cycle while not stalled.
// ============================================================================
module tem_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  tem_pkg::msg_desc_t  desc_i,
  output logic                pop_o,
  tem_out_if.source           msg_o
);
  import tem_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_HDR, S_STAMP, S_SIZE, S_TAG, S_ULEB, S_FOOT, S_ACT
  } state_e;

  localparam logic [1:0] CI_LAST = 2'd2;  // third coordinate, always zero

  state_e             st_q, st_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [1:0]         ci_q, ci_d;
  logic [STAMP_W-1:0] stamp_q, stamp_d;
  logic               max_q, max_d;
  logic [PIX_X_W-1:0] x_q, x_d;
  logic [PIX_Y_W-1:0] y_q, y_d;
  action_e            act_q, act_d;
  logic [PIX_X_W-1:0] val_q, val_d;
  logic               out_valid_q;
  logic [7:0]         out_byte_q;
  logic               out_last_q;

  logic               adv, emit, take, last_d, more;
  logic [7:0]         byte_d;
  logic [2:0]         len;

  assign adv   = !out_valid_q || msg_o.ready;
  assign pop_o = adv && take;
  // one byte per coordinate, plus one each for x and y above 127
  assign len   = 3'd3 + {2'b0, |x_q[PIX_X_W-1:7]} + {2'b0, |y_q[PIX_Y_W-1:7]};

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    ci_d    = ci_q;
    stamp_d = stamp_q;
    max_d   = max_q;
    x_d     = x_q;
    y_d     = y_q;
    act_d   = act_q;
    val_d   = val_q;
    emit    = 1'b1;
    take    = 1'b0;
    last_d  = 1'b0;
    byte_d  = '0;
    more    = 1'b0;
    case (st_q)
      S_IDLE: begin
        emit = 1'b0;
        if (!empty_i) begin
          take    = 1'b1;
          stamp_d = desc_i.stamp;
          max_d   = &desc_i.stamp;
          x_d     = desc_i.x;
          y_d     = desc_i.y;
          act_d   = desc_i.act;
          cnt_d   = '0;
          st_d    = S_HDR;
        end
      end
      S_HDR: begin
        byte_d = hdr_byte(cnt_q);
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd2) st_d = S_STAMP;
      end
      S_STAMP: begin
        more    = |stamp_q[STAMP_W-1:7];
        byte_d  = max_q ? 8'h00 : {more, stamp_q[6:0]};
        stamp_d = stamp_q >> 7;
        cnt_d   = '0;
        if (max_q || !more) st_d = S_SIZE;
      end
      S_SIZE: begin
        byte_d = size_byte(cnt_q, len);
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          ci_d = '0;
          st_d = S_TAG;
        end
      end
      S_TAG: begin
        byte_d = {3'b000, ci_q + 2'd1, 3'b000};
        case (ci_q)
          2'd0:    val_d = x_q;
          2'd1:    val_d = {1'b0, y_q};
          default: val_d = '0;
        endcase
        st_d = S_ULEB;
      end
      S_ULEB: begin
        more   = |val_q[PIX_X_W-1:7];
        byte_d = {more, val_q[6:0]};
        val_d  = val_q >> 7;
        if (!more) begin
          if (ci_q == CI_LAST) begin
            cnt_d = '0;
            st_d  = S_FOOT;
          end else begin
            ci_d = ci_q + 2'd1;
            st_d = S_TAG;
          end
        end
      end
      S_FOOT: begin
        byte_d = foot_byte(cnt_q);
        cnt_d  = cnt_q + 2'd1;
        if (cnt_q == 2'd2) st_d = S_ACT;
      end
      S_ACT: begin
        byte_d = {6'd0, act_q};
        last_d = 1'b1;
        st_d   = S_IDLE;
      end
      default: begin
        emit = 1'b0;
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      cnt_q       <= '0;
      ci_q        <= '0;
      stamp_q     <= '0;
      max_q       <= 1'b0;
      x_q         <= '0;
      y_q         <= '0;
      act_q       <= ACT_DOWN;
      val_q       <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_last_q  <= 1'b0;
    end else if (adv) begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      ci_q        <= ci_d;
      stamp_q     <= stamp_d;
      max_q       <= max_d;
      x_q         <= x_d;
      y_q         <= y_d;
      act_q       <= act_d;
      val_q       <= val_d;
      out_valid_q <= emit;
      out_byte_q  <= byte_d;
      out_last_q  <= last_d;
    end
  end

  assign msg_o.valid    = out_valid_q;
  assign msg_o.out_byte = out_byte_q;
  assign msg_o.last     = out_last_q;

`ifndef SYNTH
  a_last_is_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_byte_q[7:2] == 6'd0 && out_byte_q[1:0] != 2'b11))
    else $error("final byte is not an action code");
  a_pop_starts_msg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (st_q == S_HDR && !out_valid_q))
    else $error("dequeue did not start a message");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !msg_o.ready) |=>
      (out_valid_q && $stable(out_byte_q) && $stable(out_last_q)))
    else $error("output changed while stalled");
`endif

endmodule

### rtl/core/touch_event_message_encoder_core.sv
// ============================================================================
// Touch event message encoder core
// Scales touch positions, tracks contact state, serializes sync messages.
// ============================================================================
//
//  channel | dir | payload              | role
//  --------+-----+----------------------+----------------------------------
//  evt_i   | in  | func, raw_value,     | classified touch events
//          |     | stamp_ns             |
//  msg_o   | out | out_byte, last       | serialized message, one byte per
//          |     |                      | transaction, last on final byte
//
//  Position, contact and ignored events are absorbed in the front end.
//  A sync event takes a dequeue step plus 18..28 bytes; the
//  serializer sets the rate: one byte per cycle unless msg_o stalls.
//  Up to QueueDepth sync snapshots wait between front and back, so events
//  keep flowing while a message drains; evt_i stalls only when it is full.
//  Reset clears positions to 0, the action to DOWN and empties the queue.
//  Output is registered; a stalled msg_o holds the current byte.
//
module touch_event_message_encoder_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tem_in_if.sink     evt_i,
  tem_out_if.source  msg_o
);
  import tem_pkg::*;

  // Front/back handoff
  logic      push, full, pop, empty;
  msg_desc_t push_desc, pop_desc;

  // Front end: state update on each recognised event, snapshot on sync
  tem_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_i),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  // Decoupling queue of message snapshots
  tem_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .empty_o     (empty)
  );

  // Back end: byte serializer with registered output
  tem_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .desc_i  (pop_desc),
    .pop_o   (pop),
    .msg_o   (msg_o)
  );

endmodule

### test/testbench.sv
// ============================================================================
// Touch event message encoder testbench
// Drives touch events through the valid/ready input channel under four
// handshake pressure phases. Predicts every message byte and its last flag
// with an independent encoder model and checks each output transaction.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
  import tem_pkg::*;

  // Run length and timing
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned EVENTS_PHASE = 95;   // counted events per phase

  // X scaling: raw offset, exact rational scale, lost pixel border
  localparam int unsigned X_RAW_OFFSET = 100;
  localparam longint      X_SCALE_NUM  = 640000;
  localparam longint      X_SCALE_DEN  = 3071250;
  localparam int unsigned X_BORDER_PX  = 25;
  localparam int unsigned X_PIX_MAX    = 1023;
  // Y scaling
  localparam int unsigned Y_SCALE_NUM  = 480;
  localparam int unsigned Y_SCALE_DEN  = 4095;

  // Message framing bytes
  localparam logic [7:0] HDR0 = 8'h80, HDR1 = 8'h01, HDR2 = 8'h08;
  localparam logic [7:0] SIZE_TAG_OUTER = 8'h1a, SIZE_OUTER = 8'h09;
  localparam logic [7:0] SIZE_TAG_INNER = 8'h0a, SIZE_INNER = 8'h03;
  localparam logic [7:0] COORD_TAG_STEP = 8'h08;
  localparam logic [7:0] FOOT0 = 8'h10, FOOT1 = 8'h00, FOOT2 = 8'h18;
  localparam logic [7:0] STAMP_SATURATED = 8'h00;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  // --------------------------------------------------------------------------
  // Message scoreboard: tracks pixel/contact state, builds the expected
  // byte stream of each sync and checks output transactions in order.
  // --------------------------------------------------------------------------
  class touch_msg_board;
    msg_byte_t          expected_bytes[$];
    logic [7:0]         frame[$];
    logic [PIX_X_W-1:0] pix_x;
    logic [PIX_Y_W-1:0] pix_y;
    action_e            act;
    bit                 contact_seen;
    int                 errors;
    int                 bytes_seen;
    int                 frames_built;

    function new();
      pix_x        = '0;
      pix_y        = '0;
      act          = ACT_DOWN;
      contact_seen = 1'b0;
      errors       = 0;
      bytes_seen   = 0;
      frames_built = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    task report(string text);
      $display("[%0t] MISMATCH: %s", $realtime, text);
      errors++;
    endtask

    function logic [PIX_X_W-1:0] scale_x(logic [RAW_W-1:0] raw);
      longint q;
      if (raw <= X_RAW_OFFSET) return '0;
      q = (longint'(raw) - X_RAW_OFFSET) * X_SCALE_NUM / X_SCALE_DEN;
      if (q < X_BORDER_PX) return '0;
      q = q - X_BORDER_PX;
      if (q > X_PIX_MAX) q = X_PIX_MAX;
      return PIX_X_W'(q);
    endfunction

    function logic [PIX_Y_W-1:0] scale_y(logic [RAW_W-1:0] raw);
      return PIX_Y_W'((32'(raw) * Y_SCALE_NUM) / Y_SCALE_DEN);
    endfunction

    // LEB128 append; returns the number of bytes written
    function int add_varint(logic [63:0] value);
      logic [7:0] b;
      int         n = 0;
      do begin
        b     = {1'b0, value[6:0]};
        value = value >> 7;
        if (value != 0) b[7] = 1'b1;
        frame.push_back(b);
        n++;
      end while (value != 0);
      return n;
    endfunction

    function void build_message(logic [STAMP_W-1:0] stamp);
      logic [63:0] coord[3];
      msg_byte_t   e;
      int          s1;
      int          len;
      // No contact since the previous sync means a move report
      if (!contact_seen) act = ACT_MOVE;
      else contact_seen = 1'b0;
      frame.delete();
      frame.push_back(HDR0);
      frame.push_back(HDR1);
      frame.push_back(HDR2);
      if (&stamp) frame.push_back(STAMP_SATURATED);
      else void'(add_varint({1'b0, stamp}));
      s1 = frame.size() + 1;
      frame.push_back(SIZE_TAG_OUTER);
      frame.push_back(SIZE_OUTER);
      frame.push_back(SIZE_TAG_INNER);
      frame.push_back(SIZE_INNER);
      coord[0] = 64'(pix_x);
      coord[1] = 64'(pix_y);
      coord[2] = '0;
      for (int i = 0; i < 3; i++) begin
        frame.push_back(8'(COORD_TAG_STEP * (i + 1)));
        len = add_varint(coord[i]);
        frame[s1]     = frame[s1] + 8'(len);
        frame[s1 + 2] = frame[s1 + 2] + 8'(len);
      end
      frame.push_back(FOOT0);
      frame.push_back(FOOT1);
      frame.push_back(FOOT2);
      frame.push_back({6'd0, act});
      foreach (frame[i]) begin
        e.data = frame[i];
        e.last = (i == frame.size() - 1);
        expected_bytes.push_back(e);
      end
      frames_built++;
    endfunction

    // Called once per accepted input transaction
    function void note_event(logic [FUNC_W-1:0] fn, logic [RAW_W-1:0] raw,
                             logic [STAMP_W-1:0] stamp);
      case (fn)
        FN_POS_X:   pix_x = scale_x(raw);
        FN_POS_Y:   pix_y = scale_y(raw);
        FN_CONTACT: begin
          contact_seen = 1'b1;
          act = (raw == CONTACT_PRESSED) ? ACT_DOWN : ACT_UP;
        end
        FN_SYNC:    build_message(stamp);
        default:    ;
      endcase
    endfunction

    // Called once per accepted output transaction
    task check_byte(logic [7:0] data, logic last);
      msg_byte_t want;
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte 0x%02h last=%0b with nothing expected", data, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data)
        report($sformatf("byte %0d: got 0x%02h want 0x%02h", bytes_seen, data, want.data));
      if (last !== want.last)
        report($sformatf("byte %0d: last got %0b want %0b", bytes_seen, last, want.last));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  tem_in_if  evt ();
  tem_out_if msg ();

  touch_event_message_encoder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .msg_o  (msg)
  );

  touch_msg_board board;

  int unsigned cycles;
  int unsigned send_idle_pct;   // chance per cycle the event source holds off
  int unsigned stall_pct;       // chance per cycle the byte sink stalls
  int          kind_count[8];   // accepted events per func code
  int          counted_events;  // events the block acts on (ignored kinds excluded)

  // 50 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle watchdog: catches a hung handshake anywhere in the run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles, %0d bytes still expected", CYCLE_LIMIT,
               board.pending());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Byte sink: ready is redrawn every falling edge from the phase stall rate
  always @(negedge clk_i) begin
    msg.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every byte transaction is checked at the edge that completes it
  always @(posedge clk_i) begin
    if (rst_ni && msg.valid && msg.ready) board.check_byte(msg.out_byte, msg.last);
  end

  // One event transaction: optional idle gap, then hold valid until accepted.
  // Valid is only ever written once per falling edge.
  task automatic send_event(logic [FUNC_W-1:0] fn, logic [RAW_W-1:0] raw,
                            logic [STAMP_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      evt.valid <= 1'b0;
    end
    @(negedge clk_i);
    evt.valid     <= 1'b1;
    evt.func      <= fn;
    evt.raw_value <= raw;
    evt.stamp_ns  <= stamp;
    do @(posedge clk_i); while (!evt.ready);
    board.note_event(fn, raw, stamp);
    kind_count[fn]++;
    if (fn <= FN_SYNC) counted_events++;
  endtask

  // Source goes quiet until the scoreboard has seen every predicted byte
  task automatic drain_messages();
    @(negedge clk_i);
    evt.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [RAW_W-1:0] rand_raw();
    return RAW_W'($urandom);
  endfunction

  // Random bit length so that every varint length from 1 to 9 bytes shows up,
  // plus the occasional saturated all-ones stamp
  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] r;
    int          nb;
    r  = {$urandom, $urandom};
    nb = $urandom_range(STAMP_W);
    if ($urandom_range(19) == 0) return '1;
    return r[STAMP_W-1:0] & ((STAMP_W'(1) << nb) - 1);
  endfunction

  // Mostly well-formed gestures (positions, maybe a contact, then sync);
  // the rest is arbitrary events including the unused kinds
  task automatic random_gesture();
    logic [RAW_W-1:0] contact_val;
    if ($urandom_range(99) < 70) begin
      if ($urandom_range(3) != 0) send_event(FN_POS_X, rand_raw(), rand_stamp());
      if ($urandom_range(3) != 0) send_event(FN_POS_Y, rand_raw(), rand_stamp());
      if ($urandom_range(1) != 0) begin
        contact_val = $urandom_range(1) ? CONTACT_PRESSED : rand_raw();
        send_event(FN_CONTACT, contact_val, rand_stamp());
      end
      send_event(FN_SYNC, rand_raw(), rand_stamp());
    end else begin
      send_event(FUNC_W'($urandom_range(7)), rand_raw(), rand_stamp());
    end
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_rate);
    int goal;
    goal          = counted_events + EVENTS_PHASE;
    send_idle_pct = idle_pct;
    stall_pct     = stall_rate;
    while (counted_events < goal) random_gesture();
    drain_messages();
  endtask

  initial begin
    board          = new();
    cycles         = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    counted_events = 0;
    foreach (kind_count[i]) kind_count[i] = 0;
    rst_ni         = 1'b0;
    evt.valid      = 1'b0;
    evt.func       = '0;
    evt.raw_value  = '0;
    evt.stamp_ns   = '0;
    msg.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // ---- Directed: reset state, scaling extremes, contact and stamp corners
    send_event(FN_SYNC, '0, '0);                   // reset coords, no contact -> move
    send_event(FN_POS_X, '1, '0);                  // full-scale X
    send_event(FN_POS_Y, '1, '0);                  // full-scale Y (480)
    send_event(FN_CONTACT, CONTACT_PRESSED, '0);   // press -> down
    send_event(FN_SYNC, '0, '1);                   // saturated stamp -> single zero byte
    send_event(FN_POS_X, 12'd100, '0);             // at the offset
    send_event(FN_POS_X, 12'd101, '0);             // just past it, inside the border
    send_event(FN_POS_X, 12'd219, '0);             // last raw value below the border
    send_event(FN_POS_X, 12'd220, '0);             // exactly on the border
    send_event(FN_SYNC, '0, 63'd127);              // one-byte stamp, move again
    send_event(FN_POS_X, 12'd800, '0);
    send_event(FN_POS_Y, '0, '0);
    send_event(FN_CONTACT, '0, '0);                // release -> up
    send_event(FN_SYNC, '1, {1'b0, {62{1'b1}}} | 63'h4000000000000000 - 63'd1);
    send_event(3'd4, '1, '1);                      // unused kinds: ignored
    send_event(3'd7, '1, '1);
    send_event(FN_CONTACT, '1, '0);                // any non-one value is up
    send_event(FN_CONTACT, CONTACT_PRESSED, '0);   // latest contact wins
    send_event(FN_POS_Y, 12'd1100, '0);            // y = 128, two-byte varint
    send_event(FN_SYNC, '0, 63'd128);
    send_event(FN_POS_Y, 12'd1000, '0);            // y = 117, one-byte varint
    send_event(FN_SYNC, '0, 63'h4000000000000000); // nine-byte stamp
    drain_messages();                              // pause until all bytes are back

    // ---- Random phases: none, slow source, stalling sink, light both
    run_phase(0, 0);
    run_phase(48, 0);
    run_phase(0, 48);
    run_phase(8, 8);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.pending() != 0)
      board.report($sformatf("%0d bytes never arrived", board.pending()));

    $display("Covered %0d events: %0d x, %0d y, %0d contact, %0d sync, %0d unused kind",
             counted_events + kind_count[4] + kind_count[5] + kind_count[6] + kind_count[7],
             kind_count[FN_POS_X], kind_count[FN_POS_Y], kind_count[FN_CONTACT],
             kind_count[FN_SYNC], kind_count[4] + kind_count[5] + kind_count[6] +
             kind_count[7]);
    $display("Checked %0d bytes of %0d messages under four backpressure phases",
             board.bytes_seen, board.frames_built);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
